>>> sv/gri_pkg.sv
// ---------------------------------------------------------------------------
// gri_pkg: shared types and constants of the gyro rate and angle integrator
// Field widths, configuration register indexes, reset values and the
// operand widths of the shared multiplier.
// ---------------------------------------------------------------------------
package gri_pkg;

   localparam int ADC_W    = 12;
   localparam int TICKS_W  = 16;
   localparam int AXSEL_W  = 2;
   localparam int RATE_W   = 32;
   localparam int ANGLE_W  = 40;
   localparam int GAIN_W   = 24;
   localparam int TICKS_SEC_W = 32;
   localparam int DT_W     = TICKS_W + TICKS_SEC_W;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 216;

   // Shared multiplier: 33-bit magnitude times 24-bit operand.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Z     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_X       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_Y       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_Z       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_SECONDS = 3'd6;

   localparam logic [ADC_W-1:0]       OFFSET_RESET = 12'd2048;
   localparam logic [GAIN_W-1:0]      GAIN_RESET   = 24'd71488;
   localparam logic [TICKS_SEC_W-1:0] TICK_RESET   = 32'd4295;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_RESET  = 1'b1;

   typedef struct packed {
      logic [2:0][ADC_W-1:0]  offset;
      logic [2:0][GAIN_W-1:0] gain;
      logic [TICKS_SEC_W-1:0] tick_seconds;
   } cfg_type;

endpackage

>>> sv/gri_csr.sv
// ---------------------------------------------------------------------------
// gri_csr: configuration register file
// Holds the per-axis offsets and gains and the tick period.
// ---------------------------------------------------------------------------
module gri_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [gri_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gri_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output gri_pkg::cfg_type                cfg
);
   import gri_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OFFSET_X:     cfg_in.offset[0]    = csr_wdata[ADC_W-1:0];
            CSR_OFFSET_Y:     cfg_in.offset[1]    = csr_wdata[ADC_W-1:0];
            CSR_OFFSET_Z:     cfg_in.offset[2]    = csr_wdata[ADC_W-1:0];
            CSR_GAIN_X:       cfg_in.gain[0]      = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_Y:       cfg_in.gain[1]      = csr_wdata[GAIN_W-1:0];
            CSR_GAIN_Z:       cfg_in.gain[2]      = csr_wdata[GAIN_W-1:0];
            CSR_TICK_SECONDS: cfg_in.tick_seconds = csr_wdata[TICKS_SEC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset       <= {3{OFFSET_RESET}};
         cfg_ff.gain         <= {3{GAIN_RESET}};
         cfg_ff.tick_seconds <= TICK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/gri_mul.sv
// ---------------------------------------------------------------------------
// gri_mul: shared unsigned multiplier
// One 33 x 24 bit product per cycle, registered on the enable.
// ---------------------------------------------------------------------------
module gri_mul (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [gri_pkg::MUL_A_W-1:0] op_a,
   input  logic [gri_pkg::MUL_B_W-1:0] op_b,
   output logic [gri_pkg::PROD_W-1:0]  product
);
   import gri_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

>>> sv/gyro_rate_angle_integrator_core.sv
// ---------------------------------------------------------------------------
// gyro_rate_angle_integrator_core: three-axis gyro rate and angle integrator
// Turns gyro ADC codes into rates and integrates them with the trapezoid
// rule into saturating angles, or loads a new angle into one axis.
// ---------------------------------------------------------------------------
// Usage:
// The req channel carries one command per transaction. With req_tuser low it
// is a sample: three ADC codes and the ticks elapsed since the last sample.
// With req_tuser high it loads reset_angle into the axis named by
// reset_axis; axis value 3 (or an axis beyond AXIS_COUNT) changes nothing.
// Every transaction returns exactly one rsp transaction holding all three
// rates and angles after the update; axes beyond AXIS_COUNT report zero.
// Timing: a sample runs on one shared multiplier under a small sequencer,
// one multiply for dt and seven steps per axis (three of them multiplies);
// rsp_tvalid rises when the sequencer leaves its final step, in the same
// cycle that req_tready returns. A reset command goes from acceptance
// straight to that final step. req_tready is high only when idle.
// The result sits in an output register, so a new transaction is accepted
// while rsp is stalled; the sequencer then waits in its final step until the
// output register is free. Configuration writes are taken at any edge with
// csr_we high and must only happen while the block is idle.
// Synchronous reset clears all rates and angles to zero, restores the
// register defaults and empties the output register.
// ---------------------------------------------------------------------------
module gyro_rate_angle_integrator_core #(
   parameter int AXIS_COUNT = 3,
   parameter int ADC_BITS   = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata, lowest bit up: adc_x[11:0], adc_y[23:12], adc_z[35:24],
   // elapsed_ticks[51:36], reset_axis[53:52], reset_angle[93:54], zero pad.
   input  logic [gri_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: command (0 sample, 1 reset one axis angle).
   input  logic                            req_tuser,
   // Response channel.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata, lowest bit up: rate_x[31:0], rate_y[63:32], rate_z[95:64],
   // angle_x[135:96], angle_y[175:136], angle_z[215:176].
   output logic [gri_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [gri_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gri_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gri_pkg::*;

   // Codes and offsets are masked to ADC_BITS (at most ADC_W); the port field is 12 bits.
   localparam int CODE_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam int RMAG_W = PROD_W - 8;
   localparam int IMAG_W = PROD_W - 9;
   localparam int LOSH_W = PROD_W - 24;
   localparam int INC_W  = 50;

   localparam logic [RMAG_W-1:0] RATE_POS_LIM = RMAG_W'(64'h7FFF_FFFF);
   localparam logic [RMAG_W-1:0] RATE_NEG_LIM = RMAG_W'(64'h8000_0000);
   localparam logic [RATE_W-1:0] RATE_MAX  = {1'b0, {(RATE_W-1){1'b1}}};
   localparam logic [RATE_W-1:0] RATE_MIN  = {1'b1, {(RATE_W-1){1'b0}}};
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_DT   = 10'b00_0000_0010,
      ST_RATE = 10'b00_0000_0100,
      ST_RFIN = 10'b00_0000_1000,
      ST_SUM  = 10'b00_0001_0000,
      ST_MLO  = 10'b00_0010_0000,
      ST_MHI  = 10'b00_0100_0000,
      ST_INC  = 10'b00_1000_0000,
      ST_ANG  = 10'b01_0000_0000,
      ST_DONE = 10'b10_0000_0000
   } state_type;

   cfg_type cfg;

   state_type state_ff, state_in;
   logic [AXSEL_W-1:0] axis_ff, axis_in;

   logic [2:0][ADC_W-1:0]  adc_ff, adc_in;
   logic [TICKS_W-1:0]     ticks_ff, ticks_in;
   logic [DT_W-1:0]        dt_ff, dt_in;
   logic                   rneg_ff, rneg_in;
   logic [RATE_W-1:0]      rate_new_ff, rate_new_in;
   logic                   sneg_ff, sneg_in;
   logic [MUL_A_W-1:0]     s_ff, s_in;
   logic [LOSH_W-1:0]      lo_sh_ff, lo_sh_in;
   logic [INC_W-1:0]       inc_ff, inc_in;

   logic [2:0][RATE_W-1:0]  rate_ff, rate_in;
   logic [2:0][ANGLE_W-1:0] angle_ff, angle_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Shared multiplier interface.
   logic               mul_en;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;

   // Step datapath.
   logic [CODE_W-1:0]  code, off, diff;
   logic [PROD_W-1:0]  rnd, lo, hi;
   logic [RMAG_W-1:0]  rmag;
   logic [MUL_A_W-1:0] sum33;
   logic [IMAG_W-1:0]  imag;
   logic [INC_W-1:0]   asum;
   logic               last_axis;

   gri_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gri_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign last_axis  = (axis_ff == AXSEL_W'(AXIS_COUNT - 1));

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      adc_in       = adc_ff;
      ticks_in     = ticks_ff;
      dt_in        = dt_ff;
      rneg_in      = rneg_ff;
      rate_new_in  = rate_new_ff;
      sneg_in      = sneg_ff;
      s_in         = s_ff;
      lo_sh_in     = lo_sh_ff;
      inc_in       = inc_ff;
      rate_in      = rate_ff;
      angle_in     = angle_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      code  = adc_ff[axis_ff][CODE_W-1:0];
      off   = cfg.offset[axis_ff][CODE_W-1:0];
      diff  = (code < off) ? (off - code) : (code - off);
      rnd   = prod + PROD_W'(128);
      rmag  = rnd[PROD_W-1:8];
      sum33 = {rate_ff[axis_ff][RATE_W-1], rate_ff[axis_ff]}
            + {rate_new_ff[RATE_W-1], rate_new_ff};
      lo    = prod + (PROD_W'(1) << 32);
      hi    = prod + PROD_W'(lo_sh_ff);
      imag  = hi[PROD_W-1:9];
      asum  = {{(INC_W-ANGLE_W){angle_ff[axis_ff][ANGLE_W-1]}}, angle_ff[axis_ff]} + inc_ff;

      // The output register empties when the receiver takes the transaction.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_RESET) begin
                  // Angle load happens right at acceptance; rates are kept.
                  for (int i = 0; i < 3; i++) begin
                     if (i < AXIS_COUNT && req_tdata[53:52] == AXSEL_W'(i)) begin
                        angle_in[i] = req_tdata[93:54];
                     end
                  end
                  state_in = ST_DONE;
               end else begin
                  adc_in[0] = req_tdata[11:0];
                  adc_in[1] = req_tdata[23:12];
                  adc_in[2] = req_tdata[35:24];
                  ticks_in  = req_tdata[51:36];
                  axis_in   = '0;
                  state_in  = ST_DT;
               end
            end
         end
         ST_DT: begin
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(cfg.tick_seconds);
            mul_b    = MUL_B_W'(ticks_ff);
            state_in = ST_RATE;
         end
         ST_RATE: begin
            // The dt product is still in the multiplier for the first axis.
            if (axis_ff == '0) begin
               dt_in = prod[DT_W-1:0];
            end
            rneg_in  = (code < off);
            mul_en   = 1'b1;
            mul_a    = MUL_A_W'(diff);
            mul_b    = cfg.gain[axis_ff];
            state_in = ST_RFIN;
         end
         ST_RFIN: begin
            // Round half away from zero on the magnitude, then saturate.
            if (rneg_ff) begin
               rate_new_in = (rmag > RATE_NEG_LIM) ? RATE_MIN
                                                   : (RATE_W'(0) - rmag[RATE_W-1:0]);
            end else begin
               rate_new_in = (rmag > RATE_POS_LIM) ? RATE_MAX : rmag[RATE_W-1:0];
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sneg_in  = sum33[MUL_A_W-1];
            s_in     = sum33[MUL_A_W-1] ? (MUL_A_W'(0) - sum33) : sum33;
            state_in = ST_MLO;
         end
         ST_MLO: begin
            mul_en   = 1'b1;
            mul_a    = s_ff;
            mul_b    = dt_ff[MUL_B_W-1:0];
            state_in = ST_MHI;
         end
         ST_MHI: begin
            // Low partial product plus the rounding half of 2^33.
            lo_sh_in = lo[PROD_W-1:24];
            mul_en   = 1'b1;
            mul_a    = s_ff;
            mul_b    = dt_ff[DT_W-1:MUL_B_W];
            state_in = ST_INC;
         end
         ST_INC: begin
            inc_in   = sneg_ff ? (INC_W'(0) - INC_W'(imag)) : INC_W'(imag);
            state_in = ST_ANG;
         end
         ST_ANG: begin
            if (asum[INC_W-1:ANGLE_W-1] == {(INC_W-ANGLE_W+1){asum[INC_W-1]}}) begin
               angle_in[axis_ff] = asum[ANGLE_W-1:0];
            end else begin
               angle_in[axis_ff] = asum[INC_W-1] ? ANGLE_MIN : ANGLE_MAX;
            end
            rate_in[axis_ff] = rate_new_ff;
            if (last_axis) begin
               state_in = ST_DONE;
            end else begin
               axis_in  = axis_ff + AXSEL_W'(1);
               state_in = ST_RATE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {angle_ff[2], angle_ff[1], angle_ff[0],
                               rate_ff[2], rate_ff[1], rate_ff[0]};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= '0;
         rate_ff      <= '0;
         angle_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rate_ff      <= rate_in;
         angle_ff     <= angle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_ff      <= adc_in;
      ticks_ff    <= ticks_in;
      dt_ff       <= dt_in;
      rneg_ff     <= rneg_in;
      rate_new_ff <= rate_new_in;
      sneg_ff     <= sneg_in;
      s_ff        <= s_in;
      lo_sh_ff    <= lo_sh_in;
      inc_ff      <= inc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
